>>> rtl/fdg_pkg.sv
package fdg_pkg;

	localparam int NUM_CH  = 3;
	localparam int DIV_NW  = 128;
	localparam int DIV_DW  = 64;
	localparam int DIV_CW  = $clog2(DIV_NW);

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DOMAIN  = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_AMPLITUDE = 3'd0,
		REG_ENERGY    = 3'd1,
		REG_FLOOR0    = 3'd2,
		REG_FLOOR1    = 3'd3,
		REG_FLOOR2    = 3'd4,
		REG_KNOTS0    = 3'd5,
		REG_KNOTS1    = 3'd6,
		REG_KNOTS2    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic              is_load;
		logic [1:0]        channel;
		logic [3:0]        knot_index;
		logic signed [15:0] exposure;
		logic signed [15:0] knot_density;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [31:0]       amplitude;
		logic [16:0]       energy;
		logic [2:0][31:0]  floor_var;
		logic [2:0][4:0]   knots_used;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

	function automatic logic [31:0] fdg_pow10(logic [3:0] i);
		logic [31:0] r;
		case (i)
			4'd0: r = 32'd1;
			4'd1: r = 32'd10;
			4'd2: r = 32'd100;
			4'd3: r = 32'd1000;
			4'd4: r = 32'd10000;
			4'd5: r = 32'd100000;
			4'd6: r = 32'd1000000;
			4'd7: r = 32'd10000000;
			4'd8: r = 32'd100000000;
			default: r = 32'd1;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] fdg_isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bit_v;
		logic [63:0] rem;
		res   = '0;
		bit_v = 64'h4000_0000_0000_0000;
		rem   = v;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// 10^(2^(b-12)) in Q28, by repeated square roots of sqrt(10)
	function automatic logic [11:0][31:0] fdg_roots();
		logic [11:0][31:0] r;
		logic [63:0]       root;
		root = fdg_isqrt64(64'd10 << 56);
		for (int b = 11; b >= 0; b--) begin
			r[b] = root[31:0];
			root = fdg_isqrt64(root << 28);
		end
		return r;
	endfunction

endpackage

>>> rtl/fdg_if.sv
interface fdg_sample_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [1:0]         channel;
	logic [3:0]         knot_index;
	logic signed [15:0] exposure;
	logic signed [15:0] knot_density;
	logic               last_in_batch;

	modport source (output valid, mode, channel, knot_index, exposure, knot_density,
		last_in_batch, input ready);
	modport sink (input valid, mode, channel, knot_index, exposure, knot_density,
		last_in_batch, output ready);
endinterface

interface fdg_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] density;
	logic [15:0] grain_sigma;
	logic [1:0]  status;
	logic        batch_end;

	modport source (output valid, density, grain_sigma, status, batch_end, input ready);
	modport sink (input valid, density, grain_sigma, status, batch_end, output ready);
endinterface

interface fdg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/fdg_cfg.sv
module fdg_cfg
	import fdg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	fdg_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.amplitude  <= 32'd65536;
			regs_q.energy     <= 17'd65536;
			regs_q.floor_var  <= {3{32'd1}};
			regs_q.knots_used <= '0;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_AMPLITUDE: regs_q.amplitude     <= cfg.data;
				REG_ENERGY:    regs_q.energy        <= cfg.data[16:0];
				REG_FLOOR0:    regs_q.floor_var[0]  <= cfg.data;
				REG_FLOOR1:    regs_q.floor_var[1]  <= cfg.data;
				REG_FLOOR2:    regs_q.floor_var[2]  <= cfg.data;
				REG_KNOTS0:    regs_q.knots_used[0] <= cfg.data[4:0];
				REG_KNOTS1:    regs_q.knots_used[1] <= cfg.data[4:0];
				REG_KNOTS2:    regs_q.knots_used[2] <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/fdg_front.sv
module fdg_front
	import fdg_pkg::*;
#(
	parameter int MAX_KNOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	fdg_sample_if.sink samples,
	output item_t     head,
	output logic      head_valid,
	input  logic      pop
);

	item_t      fifo_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       keep;
	logic       push;
	item_t      item_c;

	assign samples.ready = (cnt_q != 2'd2);
	assign accept        = samples.valid && samples.ready;
	// drop loads aimed past the last curve or past the table depth
	assign keep = samples.mode ||
		(samples.channel != 2'd3 && int'(samples.knot_index) < MAX_KNOTS);
	assign push = accept && keep;

	always_comb begin
		item_c.is_load      = !samples.mode;
		item_c.channel      = samples.channel;
		item_c.knot_index   = samples.knot_index;
		item_c.exposure     = samples.exposure;
		item_c.knot_density = samples.knot_density;
		item_c.last         = samples.last_in_batch;
	end

	assign head       = fifo_q[rp_q];
	assign head_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= item_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> rtl/fdg_div.sv
module fdg_div
	import fdg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] nq_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   sh_c;
	logic              fit_c;
	logic [DIV_DW:0]   diff_c;

	// numerator shifts out the top while quotient bits shift in at the bottom
	assign sh_c   = {rem_q, nq_q[DIV_NW-1]};
	assign fit_c  = sh_c >= {1'b0, den_q};
	assign diff_c = sh_c - {1'b0, den_q};

	assign rsp.done = done_q;
	assign rsp.quo  = nq_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			nq_q  <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fit_c ? diff_c[DIV_DW-1:0] : sh_c[DIV_DW-1:0];
			nq_q  <= {nq_q[DIV_NW-2:0], fit_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/fdg_back.sv
module fdg_back
	import fdg_pkg::*;
#(
	parameter int MAX_KNOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       head,
	input  logic        head_valid,
	output logic        pop,
	input  cfg_t        cfg,
	output div_req_t    div_req,
	input  div_rsp_t    div_rsp,
	fdg_result_if.source results
);

	localparam int DEPTH = NUM_CH * MAX_KNOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [11:0][31:0] ROOTS = fdg_roots();

	typedef enum logic [4:0] {
		S_IDLE, S_LD_CMP, S_RD_FIRST, S_RD_CHK, S_SCAN, S_SEG_LO, S_SEG_CHK,
		S_INTERP, S_INTERP_WAIT, S_MUL_DY, S_MUL_DX, S_MUL_AD, S_POW,
		S_MUL_F0, S_MUL_F1, S_SCALE, S_DEN_SCALE, S_TERM, S_TERM_WAIT,
		S_S2, S_S2_WAIT, S_SQRT, S_FIN
	} state_t;

	state_t             state_q;
	logic [31:0]        mem [DEPTH];
	logic [31:0]        rd_data_q;
	logic [AW-1:0]      rd_addr;
	logic               mem_we;

	logic [1:0]         ch_q;
	logic [3:0]         k_q;
	logic signed [15:0] e_q;
	logic signed [15:0] dn_q;
	logic               last_q;
	logic [2:0]         bad_q;
	logic signed [15:0] xfirst_q;
	logic [4:0]         j_q;
	logic [4:0]         bin_q;
	logic signed [15:0] x0_q;
	logic signed [15:0] y0_q;
	logic [15:0]        dx_q;
	logic [15:0]        dy_q;
	logic [15:0]        t_q;
	logic [15:0]        d_q;
	logic [31:0]        dy2_q;
	logic [63:0]        den_q;
	logic [63:0]        ad_q;
	logic [31:0]        pacc_q;
	logic [3:0]         pb_q;
	logic [127:0]       num_q;
	logic [127:0]       sc_q;
	logic [1:0]         c_q;
	logic [32:0]        var_q;
	logic [31:0]        sq_v_q;
	logic [31:0]        sq_res_q;
	logic [31:0]        sq_bit_q;
	logic [15:0]        sigma_q;
	status_t            status_q;

	logic               out_valid_q;
	logic [15:0]        out_density_q;
	logic [15:0]        out_sigma_q;
	status_t            out_status_q;
	logic               out_last_q;

	logic signed [15:0] rx_c;
	logic signed [15:0] ry_c;
	logic [4:0]         n_c;
	logic               prof_ok_c;
	logic [16:0]        u_c;
	logic [4:0]         ue_c;
	logic               pos_c;
	logic               neg_c;
	logic [3:0]         sexp_c;
	logic [31:0]        k_c;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic               hit_c;
	logic [4:0]         cand_c;
	logic [4:0]         binc_c;
	logic [127:0]       sc_sum_c;
	logic signed [16:0] d_c;
	logic [32:0]        term_c;
	logic [32:0]        sq_trial_c;
	logic [31:0]        sq_res_n_c;
	logic               sq_fit_c;
	logic               fin_fire;

	function automatic logic [AW-1:0] kaddr(logic [1:0] c, logic [4:0] j);
		return AW'(int'(c) * MAX_KNOTS + int'(j));
	endfunction

	assign rx_c = rd_data_q[31:16];
	assign ry_c = rd_data_q[15:0];
	assign n_c  = cfg.knots_used[ch_q];

	always_comb begin
		prof_ok_c = (cfg.amplitude != '0) && (cfg.energy != '0) &&
			(cfg.energy <= 17'd65536);
		for (int c = 0; c < NUM_CH; c++) begin
			if (cfg.floor_var[c] == '0 || cfg.knots_used[c] < 5'd3 ||
				int'(cfg.knots_used[c]) > MAX_KNOTS || bad_q[c]) begin
				prof_ok_c = 1'b0;
			end
		end
	end

	// 10^(-e/4096) = 10^(ue-8) * 10^(r/4096), with u = 32768 - e
	assign u_c    = 17'h08000 - {e_q[15], e_q};
	assign ue_c   = u_c[16:12];
	assign pos_c  = ue_c > 5'd8;
	assign neg_c  = ue_c < 5'd8;
	assign sexp_c = pos_c ? 4'(ue_c - 5'd8) : 4'(5'd8 - ue_c);
	assign k_c    = fdg_pow10(sexp_c);

	assign hit_c  = e_q >= rx_c;
	assign cand_c = hit_c ? j_q : bin_q;
	assign binc_c = (cand_c > n_c - 5'd2) ? n_c - 5'd2 : cand_c;

	always_comb begin
		case (state_q)
			S_INTERP:    begin mul_a = {16'b0, t_q};  mul_b = {16'b0, dy_q}; end
			S_MUL_DY:    begin mul_a = {16'b0, dy_q}; mul_b = {16'b0, dy_q}; end
			S_MUL_DX:    begin mul_a = {16'b0, dx_q}; mul_b = {16'b0, dx_q}; end
			S_MUL_AD:    begin mul_a = cfg.amplitude; mul_b = dy2_q; end
			S_POW:       begin mul_a = pacc_q;        mul_b = ROOTS[pb_q]; end
			S_MUL_F0:    begin mul_a = ad_q[31:0];    mul_b = pacc_q; end
			S_MUL_F1:    begin mul_a = ad_q[63:32];   mul_b = pacc_q; end
			S_SCALE:     begin mul_a = num_q[{c_q, 5'b0} +: 32]; mul_b = k_c; end
			S_DEN_SCALE: begin mul_a = den_q[31:0];   mul_b = k_c; end
			default:     begin mul_a = '0;            mul_b = '0; end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign sc_sum_c = sc_q + (128'(mul_p) << {c_q, 5'b0});
	assign d_c      = {y0_q[15], y0_q} + {1'b0, div_rsp.quo[15:0]};
	assign term_c   = (|div_rsp.quo[127:32]) ? 33'h1_0000_0000 : {1'b0, div_rsp.quo[31:0]};

	assign sq_trial_c = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
	assign sq_fit_c   = {1'b0, sq_v_q} >= sq_trial_c;
	assign sq_res_n_c = sq_fit_c ? (sq_res_q >> 1) + sq_bit_q : sq_res_q >> 1;

	always_comb begin
		case (state_q)
			S_IDLE:     rd_addr = head.is_load ? kaddr(head.channel, 5'(head.knot_index - 4'd1))
			                                   : kaddr(head.channel, 5'd0);
			S_RD_FIRST: rd_addr = kaddr(ch_q, n_c - 5'd1);
			S_RD_CHK:   rd_addr = kaddr(ch_q, 5'd1);
			S_SCAN:     rd_addr = (j_q == n_c - 5'd1) ? kaddr(ch_q, binc_c)
			                                         : kaddr(ch_q, j_q + 5'd1);
			S_SEG_LO:   rd_addr = kaddr(ch_q, bin_q + 5'd1);
			default:    rd_addr = kaddr(ch_q, {1'b0, k_q});
		endcase
	end

	assign mem_we = (state_q == S_LD_CMP);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[kaddr(ch_q, {1'b0, k_q})] <= {e_q, dn_q};
		end
		rd_data_q <= mem[rd_addr];
	end

	assign pop = (state_q == S_IDLE) && head_valid;

	// hand the finished result over when the output register is free
	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || results.ready);

	always_comb begin
		div_req.start = (state_q == S_INTERP) || (state_q == S_TERM) || (state_q == S_S2);
		case (state_q)
			S_INTERP: begin
				div_req.num = 128'(mul_p);
				div_req.den = 64'(dx_q);
			end
			S_TERM: begin
				div_req.num = num_q >> 20;
				div_req.den = den_q;
			end
			default: begin
				div_req.num = 128'(var_q) << 16;
				div_req.den = 64'(cfg.energy);
			end
		endcase
	end

	assign results.valid       = out_valid_q;
	assign results.density     = out_density_q;
	assign results.grain_sigma = out_sigma_q;
	assign results.status      = out_status_q;
	assign results.batch_end   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bad_q       <= 3'b111;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						ch_q   <= head.channel;
						k_q    <= head.knot_index;
						e_q    <= head.exposure;
						dn_q   <= head.knot_density;
						last_q <= head.last;
						if (head.is_load) begin
							state_q <= S_LD_CMP;
						end else if (head.channel == 2'd3 || !prof_ok_c) begin
							status_q <= ST_INVALID;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_RD_FIRST;
						end
					end
				end
				S_LD_CMP: begin
					// knot 0 restarts the curve; later knots must climb
					if (k_q == 4'd0) begin
						bad_q[ch_q] <= 1'b0;
					end else if (e_q <= rx_c || dn_q < ry_c) begin
						bad_q[ch_q] <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_RD_FIRST: begin
					xfirst_q <= rx_c;
					state_q  <= S_RD_CHK;
				end
				S_RD_CHK: begin
					if (e_q < xfirst_q || e_q > rx_c) begin
						status_q <= ST_DOMAIN;
						state_q  <= S_FIN;
					end else begin
						j_q     <= 5'd1;
						bin_q   <= 5'd0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (j_q == n_c - 5'd1) begin
						bin_q   <= binc_c;
						state_q <= S_SEG_LO;
					end else begin
						bin_q <= cand_c;
						j_q   <= j_q + 5'd1;
					end
				end
				S_SEG_LO: begin
					x0_q    <= rx_c;
					y0_q    <= ry_c;
					state_q <= S_SEG_CHK;
				end
				S_SEG_CHK: begin
					if (rx_c <= x0_q || ry_c < y0_q || e_q < x0_q || e_q > rx_c) begin
						status_q <= ST_INVALID;
						state_q  <= S_FIN;
					end else begin
						dx_q    <= 16'(rx_c - x0_q);
						dy_q    <= 16'(ry_c - y0_q);
						t_q     <= 16'(e_q - x0_q);
						state_q <= S_INTERP;
					end
				end
				S_INTERP: begin
					state_q <= S_INTERP_WAIT;
				end
				S_INTERP_WAIT: begin
					if (div_rsp.done) begin
						if (d_c[16]) begin
							status_q <= ST_DOMAIN;
							state_q  <= S_FIN;
						end else begin
							d_q     <= d_c[15:0];
							state_q <= S_MUL_DY;
						end
					end
				end
				S_MUL_DY: begin
					dy2_q   <= mul_p[31:0];
					state_q <= S_MUL_DX;
				end
				S_MUL_DX: begin
					den_q   <= mul_p;
					state_q <= S_MUL_AD;
				end
				S_MUL_AD: begin
					ad_q    <= mul_p;
					pacc_q  <= 32'h1000_0000;
					pb_q    <= 4'd11;
					state_q <= S_POW;
				end
				S_POW: begin
					if (u_c[pb_q]) begin
						pacc_q <= mul_p[59:28];
					end
					if (pb_q == 4'd0) begin
						state_q <= S_MUL_F0;
					end else begin
						pb_q <= pb_q - 4'd1;
					end
				end
				S_MUL_F0: begin
					num_q   <= 128'(mul_p);
					state_q <= S_MUL_F1;
				end
				S_MUL_F1: begin
					num_q <= num_q + (128'(mul_p) << 32);
					c_q   <= 2'd0;
					sc_q  <= '0;
					if (pos_c) begin
						state_q <= S_SCALE;
					end else if (neg_c) begin
						state_q <= S_DEN_SCALE;
					end else begin
						state_q <= S_TERM;
					end
				end
				S_SCALE: begin
					sc_q <= sc_sum_c;
					c_q  <= c_q + 2'd1;
					if (c_q == 2'd2) begin
						num_q   <= sc_sum_c;
						state_q <= S_TERM;
					end
				end
				S_DEN_SCALE: begin
					den_q   <= mul_p;
					state_q <= S_TERM;
				end
				S_TERM: begin
					state_q <= S_TERM_WAIT;
				end
				S_TERM_WAIT: begin
					if (div_rsp.done) begin
						var_q   <= {1'b0, cfg.floor_var[ch_q]} + term_c;
						state_q <= S_S2;
					end
				end
				S_S2: begin
					state_q <= S_S2_WAIT;
				end
				S_S2_WAIT: begin
					if (div_rsp.done) begin
						if (|div_rsp.quo[127:32]) begin
							sigma_q  <= 16'hFFFF;
							status_q <= ST_OK;
							state_q  <= S_FIN;
						end else begin
							sq_v_q   <= div_rsp.quo[31:0];
							sq_res_q <= '0;
							sq_bit_q <= 32'h4000_0000;
							state_q  <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (sq_fit_c) begin
						sq_v_q <= 32'({1'b0, sq_v_q} - sq_trial_c);
					end
					sq_res_q <= sq_res_n_c;
					sq_bit_q <= sq_bit_q >> 2;
					if (sq_bit_q == 32'd1) begin
						sigma_q  <= sq_res_n_c[15:0];
						status_q <= (sq_res_n_c == '0) ? ST_DOMAIN : ST_OK;
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (fin_fire) begin
						out_density_q <= (status_q == ST_OK) ? d_q : '0;
						out_sigma_q   <= (status_q == ST_OK) ? sigma_q : '0;
						out_status_q  <= status_q;
						out_last_q    <= last_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/film_density_and_grain_sigma.sv
// Channel   Dir  Beat contents
// samples   in   mode, channel, knot_index, exposure, knot_density, last_in_batch
// results   out  density, grain_sigma, status, batch_end (one per sample item)
// cfg       in   index, data (register write, always ready)
//
// A knot load passes S_IDLE and S_LD_CMP in the back end; loads to a missing curve or
// knot vanish. For a sample the shared 128-step restoring divider runs three times,
// the knot scan reads one entry per cycle, and S_SCALE is added when the power of ten
// scales the numerator.
// Early errors go straight to S_FIN from the state that finds them.
// Reset loads the register defaults and marks all three curves bad; knot tables are
// not cleared and must be loaded before use.
// A two-entry queue and the result register let input and output stall independently.
module film_density_and_grain_sigma
	import fdg_pkg::*;
#(
	parameter int MAX_KNOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	fdg_sample_if.sink    samples,
	fdg_result_if.source  results,
	fdg_cfg_if.sink       cfg
);

	item_t    head;
	logic     head_valid;
	logic     pop;
	cfg_t     regs;
	div_req_t div_req;
	div_rsp_t div_rsp;

	fdg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	fdg_front #(.MAX_KNOTS(MAX_KNOTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	fdg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fdg_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.cfg        (regs),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.results    (results)
	);

endmodule

>>> rtl/fdg_chk.sv
module fdg_chk
	import fdg_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] density,
	input logic [15:0] grain_sigma,
	input logic [1:0]  status
);

	// an error beat carries no density and no sigma
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> density == 16'd0 && grain_sigma == 16'd0)
		else $error("error beat with nonzero payload");

	// a good beat has a positive sigma and a density that fits a signed knot value
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> grain_sigma != 16'd0 && !density[15])
		else $error("good beat out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(density) &&
		$stable(grain_sigma) && $stable(status))
		else $error("stalled result changed");

endmodule

bind film_density_and_grain_sigma fdg_chk u_fdg_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.density     (results.density),
	.grain_sigma (results.grain_sigma),
	.status      (results.status)
);
